### sv/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the abelian square counter
// Payload structs of the request and response channels, field widths,
// register indexes and reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package asc_pkg;

   localparam int MAX_PERIOD_DEF = 40;
   localparam int COUNT_BITS_DEF = 7;

   localparam int LETTER_BITS   = 2;
   localparam int POS_BITS      = 10;
   localparam int TOTAL_BITS    = 16;
   localparam int EH_BITS       = 6;
   localparam int MP_BITS       = 6;
   localparam int SEAM_BITS     = 10;
   localparam int LETTERS       = 3;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_PERIOD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SEAM_POS   = 2'd1;

   localparam logic [MP_BITS-1:0]    MAX_PERIOD_RST = 6'd40;
   localparam logic [SEAM_BITS-1:0]  SEAM_POS_RST   = 10'd0;
   localparam logic [POS_BITS-1:0]   POS_MAX        = 10'd1023;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX      = 16'hFFFF;

   typedef struct packed {
      logic [LETTER_BITS-1:0] letter;
      logic                   last;
   } asc_req_type;

   typedef struct packed {
      logic [EH_BITS-1:0]    ending_here;
      logic [TOTAL_BITS-1:0] running_total;
      logic                  any_found;
      logic                  word_done;
   } asc_rsp_type;

endpackage

`default_nettype wire

### sv/asc_hist.sv
// ----------------------------------------------------------------------------
// asc_hist: circular prefix history
// Holds the last DEPTH prefix count words. A read names an entry by its age
// (1 = the prefix before the newest); read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_hist #(
   parameter int DEPTH    = 80,
   parameter int WIDTH    = 21,
   parameter int OFF_BITS = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [WIDTH-1:0]    wr_data,
   input  wire logic                rd_en,
   input  wire logic [OFF_BITS-1:0] rd_off_a,
   input  wire logic [OFF_BITS-1:0] rd_off_b,
   output      logic [WIDTH-1:0]    rd_data_a,
   output      logic [WIDTH-1:0]    rd_data_b
);

   localparam int A_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW     = ((A_BITS > OFF_BITS) ? A_BITS : OFF_BITS) + 1;

   logic [WIDTH-1:0]  mem [DEPTH];
   logic [A_BITS-1:0] wp_ff, wp_in;
   logic [A_BITS-1:0] addr_a, addr_b;
   logic [WIDTH-1:0]  rd_a_ff, rd_b_ff;

   // age to address: wp - off, wrapped into the buffer
   function automatic logic [A_BITS-1:0] age_addr(input logic [A_BITS-1:0] wp,
                                                  input logic [OFF_BITS-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(wp) + SW'(DEPTH) - SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[A_BITS-1:0];
   endfunction

   always_comb begin
      addr_a = age_addr(wp_ff, rd_off_a);
      addr_b = age_addr(wp_ff, rd_off_b);
      wp_in  = wp_ff;
      if (wr_en) begin
         wp_in = (wp_ff == A_BITS'(DEPTH - 1)) ? '0 : wp_ff + A_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

### sv/asc_match.sv
// ----------------------------------------------------------------------------
// asc_match: shared half compare unit
// Tells whether the two halves between three prefix words hold equal counts
// of every letter, with counts taken modulo 2^COUNT_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_match #(
   parameter int COUNT_BITS = 7
) (
   input  wire logic [3*COUNT_BITS-1:0] newest,
   input  wire logic [3*COUNT_BITS-1:0] middle,
   input  wire logic [3*COUNT_BITS-1:0] oldest,
   output      logic                    match
);

   logic [COUNT_BITS-1:0] newer [3];
   logic [COUNT_BITS-1:0] older [3];

   always_comb begin
      match = 1'b1;
      for (int c = 0; c < 3; c++) begin
         newer[c] = newest[c*COUNT_BITS +: COUNT_BITS] - middle[c*COUNT_BITS +: COUNT_BITS];
         older[c] = middle[c*COUNT_BITS +: COUNT_BITS] - oldest[c*COUNT_BITS +: COUNT_BITS];
         if (newer[c] != older[c]) begin
            match = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### sv/abelian_square_counter.sv
// ----------------------------------------------------------------------------
// abelian_square_counter: abelian squares in a ternary word, letter by letter
// Takes one letter per request transaction (0=a, 1=b, 2=c, with a last flag)
// and returns one response transaction per letter: the number of abelian
// squares of half length 2 or more ending at that letter, a running total
// saturating at 65535, a found flag and word_done, an echo of last. After
// the last letter the word state restarts. Two configuration registers are
// written over the csr_ channel: index 0 max_period (largest half length,
// clipped to MAX_PERIOD), index 1 seam_pos (nonzero: count only squares
// straddling that boundary). Timing: after acceptance a letter occupies the
// block while L = min(max_period, MAX_PERIOD, n/2) - 1 periods (at least 0)
// are checked and then until its response loads; the one shared compare unit
// checks one period per cycle from the two history read ports.
// req_ready is high only while the sequencer idles. The response sits in an
// output register, so a new letter is accepted while it waits; a stalled
// receiver holds the block only when the next response is ready to load.
// Reset is synchronous: word state clears, registers return to 40 and 0.
// Reset needs no clearing pass: history entries are only read after this
// word has written them.
// ----------------------------------------------------------------------------
`default_nettype none

module abelian_square_counter #(
   parameter int MAX_PERIOD = asc_pkg::MAX_PERIOD_DEF,
   parameter int COUNT_BITS = asc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire asc_pkg::asc_req_type                req_payload,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      asc_pkg::asc_rsp_type                rsp_payload,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [asc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [asc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import asc_pkg::*;

   localparam int P_BITS = $clog2(MAX_PERIOD + 2);          // holds MAX_PERIOD + 1
   localparam int K_BITS = P_BITS + 1;                      // holds 2p
   localparam int L_BITS = (P_BITS > MP_BITS) ? P_BITS : MP_BITS;
   localparam int NW     = ((K_BITS > POS_BITS) ? K_BITS : POS_BITS) + 1;
   localparam int PW     = 3 * COUNT_BITS;
   localparam int DEPTH  = 2 * MAX_PERIOD;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   // sequencer and word state
   logic [1:0]                       state_ff, state_in;
   logic [2:0][COUNT_BITS-1:0]       newest_ff, newest_in;
   logic [POS_BITS-1:0]              pos_ff, pos_in;
   logic [TOTAL_BITS-1:0]            total_ff, total_in;
   logic                             found_ff, found_in;
   logic [P_BITS-1:0]                p_ff, p_in;
   logic [P_BITS-1:0]                limit_ff, limit_in;
   logic [EH_BITS-1:0]               count_ff, count_in;
   logic                             last_ff, last_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic                             seam_ok_ff, seam_ok_in;

   // configuration
   logic [MP_BITS-1:0]               max_period_ff, max_period_in;
   logic [SEAM_BITS-1:0]             seam_ff, seam_in;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   asc_rsp_type                      rsp_ff, rsp_in;

   // history and compare
   logic                             hist_wr, hist_rd;
   logic [K_BITS-1:0]                two_p;
   logic [PW-1:0]                    mid_word, old_word;
   logic                             halves_eq;

   // period loop terms
   logic [NW-1:0]                    n_ext, two_p_ext, start_ext, seam_ext;
   logic                             p_ok, seam_ok;
   logic [L_BITS-1:0]                mp_ext, cap_ext, lim_ext;
   logic [TOTAL_BITS:0]              sum;

   logic                             accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign two_p   = {p_ff, 1'b0};
   assign hist_wr = accept;
   assign hist_rd = (state_ff == S_RUN) && p_ok;

   asc_hist #(
      .DEPTH    (DEPTH),
      .WIDTH    (PW),
      .OFF_BITS (K_BITS)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (hist_wr),
      .wr_data   (newest_ff),
      .rd_en     (hist_rd),
      .rd_off_a  (K_BITS'(p_ff)),
      .rd_off_b  (two_p),
      .rd_data_a (mid_word),
      .rd_data_b (old_word)
   );

   asc_match #(
      .COUNT_BITS (COUNT_BITS)
   ) u_match (
      .newest (newest_ff),
      .middle (mid_word),
      .oldest (old_word),
      .match  (halves_eq)
   );

   // period checks against the current position and seam
   always_comb begin
      n_ext     = NW'(pos_ff);
      two_p_ext = NW'(two_p);
      start_ext = n_ext - two_p_ext;
      seam_ext  = NW'(seam_ff);
      p_ok      = (p_ff <= limit_ff) && (two_p_ext <= n_ext);
      seam_ok   = (seam_ff == '0) || ((start_ext < seam_ext) && (n_ext > seam_ext));
      mp_ext    = L_BITS'(max_period_ff);
      cap_ext   = L_BITS'(MAX_PERIOD);
      lim_ext   = (mp_ext > cap_ext) ? cap_ext : mp_ext;
      sum       = {1'b0, total_ff} + (TOTAL_BITS + 1)'(count_ff);
   end

   // configuration writes
   always_comb begin
      max_period_in = max_period_ff;
      seam_in       = seam_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_PERIOD: max_period_in = csr_data[MP_BITS-1:0];
            REG_SEAM_POS:   seam_in       = csr_data[SEAM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      newest_in    = newest_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      found_in     = found_ff;
      p_in         = p_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rd_vld_in    = 1'b0;
      seam_ok_in   = seam_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // shift in the new prefix: old newest goes to the history
               for (int c = 0; c < LETTERS; c++) begin
                  if (req_payload.letter == LETTER_BITS'(c)) begin
                     newest_in[c] = newest_ff[c] + COUNT_BITS'(1);
                  end
               end
               pos_in   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_BITS'(1);
               limit_in = P_BITS'(lim_ext);
               p_in     = P_BITS'(2);
               count_in = '0;
               last_in  = req_payload.last;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // score the period read last cycle
            if (rd_vld_ff && seam_ok_ff && halves_eq) begin
               count_in = count_ff + EH_BITS'(1);
            end
            if (p_ok) begin
               // issue the reads for this period, advance
               rd_vld_in  = 1'b1;
               seam_ok_in = seam_ok;
               p_in       = p_ff + P_BITS'(1);
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_in.ending_here        = count_ff;
               rsp_in.running_total      = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
               rsp_in.any_found          = found_ff || (count_ff != '0);
               rsp_in.word_done          = last_ff;
               total_in                  = rsp_in.running_total;
               found_in                  = rsp_in.any_found;
               if (last_ff) begin
                  // word closed: drop its state
                  newest_in = '0;
                  pos_in    = '0;
                  total_in  = '0;
                  found_in  = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         newest_ff     <= '0;
         pos_ff        <= '0;
         total_ff      <= '0;
         found_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_period_ff <= MAX_PERIOD_RST;
         seam_ff       <= SEAM_POS_RST;
      end else begin
         state_ff      <= state_in;
         newest_ff     <= newest_in;
         pos_ff        <= pos_in;
         total_ff      <= total_in;
         found_ff      <= found_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_period_ff <= max_period_in;
         seam_ff       <= seam_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      limit_ff   <= limit_in;
      count_ff   <= count_in;
      last_ff    <= last_in;
      seam_ok_ff <= seam_ok_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire
